>>> hdl/rbst_pkg.sv
// Shared types, constants and helper functions for the ray/box slab test.
`default_nettype none

package rbst_pkg;

    // Coordinate format: signed Q16.16
    localparam int CW      = 32;
    localparam int FRAC    = 16;
    localparam int NAXES   = 3;

    // Reciprocal divider: dividend is 1.0 in Q16.16 times 2^16, i.e. 2^32
    localparam int QW              = CW + 1;
    localparam int DIVIDEND_BIT    = 2 * FRAC;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIV_TOP_BIT     = DIV_STAGES * STEPS_PER_STAGE - 1;
    // input register + divider stages + saturation register
    localparam int RECIP_LAT       = DIV_STAGES + 2;

    // Plane distance widths
    localparam int DW = CW + 1;          // plane - origin
    localparam int PW = DW + CW;         // product with reciprocal
    localparam int SW = PW - FRAC;       // product after the Q16.16 shift

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord COORD_TOP    = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_BOTTOM = {1'b1, {(CW-1){1'b0}}};

    // Fields that ride alongside the reciprocal pipeline
    typedef struct packed {
        t_coord [NAXES-1:0] org;
        t_coord [NAXES-1:0] lo;
        t_coord [NAXES-1:0] hi;
        t_coord             t0;
        t_coord             t1;
    } t_side;

    // Partial remainder / quotient of the restoring divider
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QW-1:0] quo;
    } t_div;

    // A group of restoring division steps on the constant dividend 2^32
    function automatic t_div div_chunk(input t_div cur, input logic [CW-1:0] den,
                                       input int first_bit);
        t_div        res;
        logic [CW:0] trial;
        int          j;
        res = cur;
        for (int b = 0; b < STEPS_PER_STAGE; b++) begin
            j     = first_bit - b;
            trial = {res.rem, (j == DIVIDEND_BIT)};
            if (trial >= {1'b0, den}) begin
                trial   = trial - {1'b0, den};
                res.rem = trial[CW-1:0];
                res.quo = {res.quo[QW-2:0], 1'b1};
            end else begin
                res.rem = trial[CW-1:0];
                res.quo = {res.quo[QW-2:0], 1'b0};
            end
        end
        return res;
    endfunction

    // Saturate a shifted product to the coordinate range
    function automatic t_coord sat_coord(input logic [SW-1:0] v);
        if (v[SW-1:CW-1] == {(SW-CW+1){1'b0}} || v[SW-1:CW-1] == {(SW-CW+1){1'b1}}) begin
            return t_coord'(v[CW-1:0]);
        end else if (v[SW-1]) begin
            return COORD_BOTTOM;
        end else begin
            return COORD_TOP;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/rbst_recip.sv
// Pipelined Q16.16 reciprocal (1.0 / d) with saturation, one lane.
`default_nettype none

module rbst_recip
    import rbst_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_coord i_d,
    output t_coord      o_inv
);

    // Input stage: magnitude and sign
    logic [CW-1:0] r_abs;
    logic          r_neg;
    logic          r_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= i_d[CW-1] ? (CW'(0) - i_d) : i_d;
            r_neg  <= i_d[CW-1];
            r_zero <= (i_d == t_coord'(0));
        end
    end

    // Divider stages, STEPS_PER_STAGE quotient bits each
    t_div          r_div  [DIV_STAGES];
    logic [CW-1:0] r_den  [DIV_STAGES];
    logic          r_sneg [DIV_STAGES];
    logic          r_szero[DIV_STAGES];
    t_div          n_div  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb begin
                n_div[k] = div_chunk('0, r_abs, DIV_TOP_BIT);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div[k]   <= n_div[k];
                    r_den[k]   <= r_abs;
                    r_sneg[k]  <= r_neg;
                    r_szero[k] <= r_zero;
                end
            end
        end else begin : g_rest
            always_comb begin
                n_div[k] = div_chunk(r_div[k-1], r_den[k-1],
                                     DIV_TOP_BIT - k * STEPS_PER_STAGE);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div[k]   <= n_div[k];
                    r_den[k]   <= r_den[k-1];
                    r_sneg[k]  <= r_sneg[k-1];
                    r_szero[k] <= r_szero[k-1];
                end
            end
        end
    end

    // Sign and saturation
    logic [QW-1:0] quo;
    logic [QW-1:0] neg_quo;
    t_coord        n_inv;
    t_coord        r_inv;

    always_comb begin
        quo     = r_div[DIV_STAGES-1].quo;
        neg_quo = QW'(0) - quo;
        if (r_szero[DIV_STAGES-1]) begin
            n_inv = COORD_TOP;
        end else if (!r_sneg[DIV_STAGES-1]) begin
            n_inv = (quo[QW-1] || quo[QW-2]) ? COORD_TOP : t_coord'(quo[CW-1:0]);
        end else if (quo > {2'b01, {(QW-2){1'b0}}}) begin
            n_inv = COORD_BOTTOM;
        end else begin
            n_inv = t_coord'(neg_quo[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inv <= n_inv;
        end
    end

    assign o_inv = r_inv;

endmodule

`default_nettype wire

>>> hdl/ray_box_slab_test.sv
// Top level: ray versus axis-aligned box slab test, Q16.16, fully pipelined.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   origin, dir, box corners, t window
//  output   out        o_out_valid / i_out_stall hit, slabs_overlap, t_near
//
// One transfer per cycle on each side when nothing stalls.
// Stages: reciprocal, plane select, product, shift, x/y merge, z merge, output.
// A stalled output freezes the whole pipeline; o_in_stall follows it.
// Synchronous active-low reset clears all valid bits.
`default_nettype none

module ray_box_slab_test
    import rbst_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t_coord        i_origin_x,
    input  wire t_coord        i_origin_y,
    input  wire t_coord        i_origin_z,
    input  wire t_coord        i_dir_x,
    input  wire t_coord        i_dir_y,
    input  wire t_coord        i_dir_z,
    input  wire t_coord        i_box_min_x,
    input  wire t_coord        i_box_min_y,
    input  wire t_coord        i_box_min_z,
    input  wire logic [63:0]   i_box_max_packed,
    input  wire t_coord        i_box_max_z,
    input  wire logic [63:0]   i_t_window,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_hit,
    output logic               o_slabs_overlap,
    output t_coord             o_t_near
);

    // Global advance: move when the output register is free or being taken
    logic en;
    logic r_o_v;
    assign en         = !r_o_v || !i_out_stall;
    assign o_in_stall = !en;

    // Reciprocals of the direction components
    t_coord inv[NAXES];
    t_coord dir[NAXES];
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    for (genvar a = 0; a < NAXES; a++) begin : g_recip
        rbst_recip u_recip (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (dir[a]),
            .o_inv (inv[a])
        );
    end

    // Sideband delay line matching the reciprocal latency
    t_side n_side;
    t_side r_side[RECIP_LAT];
    logic  r_side_v[RECIP_LAT];

    always_comb begin
        n_side.org[0] = i_origin_x;
        n_side.org[1] = i_origin_y;
        n_side.org[2] = i_origin_z;
        n_side.lo[0]  = i_box_min_x;
        n_side.lo[1]  = i_box_min_y;
        n_side.lo[2]  = i_box_min_z;
        n_side.hi[0]  = t_coord'(i_box_max_packed[63:32]);
        n_side.hi[1]  = t_coord'(i_box_max_packed[31:0]);
        n_side.hi[2]  = i_box_max_z;
        n_side.t0     = t_coord'(i_t_window[63:32]);
        n_side.t1     = t_coord'(i_t_window[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < RECIP_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RECIP_LAT; k++) begin
                r_side_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_side_v[0] <= i_in_valid;
            for (int k = 1; k < RECIP_LAT; k++) begin
                r_side_v[k] <= r_side_v[k-1];
            end
        end
    end

    // Plane select and plane - origin differences
    logic signed [DW-1:0] r_p_dent[NAXES];
    logic signed [DW-1:0] r_p_dext[NAXES];
    t_coord               r_p_inv [NAXES];
    t_coord               r_p_t0, r_p_t1;
    logic                 r_p_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NAXES; a++) begin
                r_p_inv[a] <= inv[a];
                if (inv[a][CW-1]) begin
                    r_p_dent[a] <= DW'($signed(r_side[RECIP_LAT-1].hi[a]))
                                 - DW'($signed(r_side[RECIP_LAT-1].org[a]));
                    r_p_dext[a] <= DW'($signed(r_side[RECIP_LAT-1].lo[a]))
                                 - DW'($signed(r_side[RECIP_LAT-1].org[a]));
                end else begin
                    r_p_dent[a] <= DW'($signed(r_side[RECIP_LAT-1].lo[a]))
                                 - DW'($signed(r_side[RECIP_LAT-1].org[a]));
                    r_p_dext[a] <= DW'($signed(r_side[RECIP_LAT-1].hi[a]))
                                 - DW'($signed(r_side[RECIP_LAT-1].org[a]));
                end
            end
            r_p_t0 <= r_side[RECIP_LAT-1].t0;
            r_p_t1 <= r_side[RECIP_LAT-1].t1;
        end
    end

    // Products with the reciprocal
    logic signed [PW-1:0] r_m_ent[NAXES];
    logic signed [PW-1:0] r_m_ext[NAXES];
    t_coord               r_m_t0, r_m_t1;
    logic                 r_m_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NAXES; a++) begin
                r_m_ent[a] <= PW'(r_p_dent[a]) * PW'(r_p_inv[a]);
                r_m_ext[a] <= PW'(r_p_dext[a]) * PW'(r_p_inv[a]);
            end
            r_m_t0 <= r_p_t0;
            r_m_t1 <= r_p_t1;
        end
    end

    // Floor shift back to Q16.16 and saturate
    t_coord r_c_ent[NAXES];
    t_coord r_c_ext[NAXES];
    t_coord r_c_t0, r_c_t1;
    logic   r_c_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NAXES; a++) begin
                r_c_ent[a] <= sat_coord(r_m_ent[a][PW-1:FRAC]);
                r_c_ext[a] <= sat_coord(r_m_ext[a][PW-1:FRAC]);
            end
            r_c_t0 <= r_m_t0;
            r_c_t1 <= r_m_t1;
        end
    end

    // Merge x and y slabs
    t_coord r_x_tmin, r_x_tmax, r_x_ent2, r_x_ext2, r_x_t0, r_x_t1;
    logic   r_x_ok;
    logic   r_x_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_ok   <= !(($signed(r_c_ent[0]) > $signed(r_c_ext[1]))
                       || ($signed(r_c_ent[1]) > $signed(r_c_ext[0])));
            r_x_tmin <= ($signed(r_c_ent[1]) > $signed(r_c_ent[0])) ? r_c_ent[1] : r_c_ent[0];
            r_x_tmax <= ($signed(r_c_ext[1]) < $signed(r_c_ext[0])) ? r_c_ext[1] : r_c_ext[0];
            r_x_ent2 <= r_c_ent[2];
            r_x_ext2 <= r_c_ext[2];
            r_x_t0   <= r_c_t0;
            r_x_t1   <= r_c_t1;
        end
    end

    // Merge z slab
    t_coord r_z_tmin, r_z_tmax, r_z_t0, r_z_t1;
    logic   r_z_ok;
    logic   r_z_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z_ok   <= r_x_ok && !(($signed(r_x_tmin) > $signed(r_x_ext2))
                                 || ($signed(r_x_ent2) > $signed(r_x_tmax)));
            r_z_tmin <= ($signed(r_x_ent2) > $signed(r_x_tmin)) ? r_x_ent2 : r_x_tmin;
            r_z_tmax <= ($signed(r_x_ext2) < $signed(r_x_tmax)) ? r_x_ext2 : r_x_tmax;
            r_z_t0   <= r_x_t0;
            r_z_t1   <= r_x_t1;
        end
    end

    // Output register
    logic   r_o_hit;
    logic   r_o_ovl;
    t_coord r_o_near;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_ovl  <= r_z_ok;
            r_o_hit  <= r_z_ok && ($signed(r_z_tmin) < $signed(r_z_t1))
                               && ($signed(r_z_tmax) > $signed(r_z_t0));
            if (!r_z_ok) begin
                r_o_near <= t_coord'(0);
            end else begin
                r_o_near <= ($signed(r_z_tmin) < $signed(r_z_tmax)) ? r_z_tmin : r_z_tmax;
            end
        end
    end

    // Valid bits of the back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_m_v <= 1'b0;
            r_c_v <= 1'b0;
            r_x_v <= 1'b0;
            r_z_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_side_v[RECIP_LAT-1];
            r_m_v <= r_p_v;
            r_c_v <= r_m_v;
            r_x_v <= r_c_v;
            r_z_v <= r_x_v;
            r_o_v <= r_z_v;
        end
    end

    assign o_out_valid     = r_o_v;
    assign o_hit           = r_o_hit;
    assign o_slabs_overlap = r_o_ovl;
    assign o_t_near        = r_o_near;

    // A hit always comes with overlapping slabs
    a_hit_needs_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (!r_o_hit || r_o_ovl))
        else $error("hit without slab overlap");

    // Early reject reports a zero distance
    a_reject_zero_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o_ovl) |-> (r_o_near == t_coord'(0)))
        else $error("nonzero t_near on rejected ray");

    // A stalled pipeline holds its last stage valid
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && i_out_stall) |=> (r_o_v && $stable(r_o_near) && $stable(r_z_v)))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

>>> verif/tb_ray_box_slab_test.sv
// Self-checking testbench for the ray versus box slab test block.
`default_nettype none

module tb_ray_box_slab_test;
    import rbst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_coord [2:0] org;
        t_coord [2:0] dir;
        t_coord [2:0] lo;
        logic [63:0]  hi_xy;
        t_coord       hi_z;
        logic [63:0]  win;
    } t_ray_box;

    typedef struct packed {
        logic   hit;
        logic   overlap;
        t_coord t_near;
    } t_slab_res;

    localparam longint TOP = 64'sd2147483647;
    localparam longint BOT = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_ray_box cur_ray = '0;
    logic o_in_stall, o_out_valid, o_hit, o_slabs_overlap;
    t_coord o_t_near;

    t_ray_box  ray_queue[$];
    t_slab_res expected_hits[$];
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  failed = 0;
    bit  in_taken = 0;

    ray_box_slab_test i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_origin_x(cur_ray.org[0]), .i_origin_y(cur_ray.org[1]),
        .i_origin_z(cur_ray.org[2]),
        .i_dir_x(cur_ray.dir[0]), .i_dir_y(cur_ray.dir[1]), .i_dir_z(cur_ray.dir[2]),
        .i_box_min_x(cur_ray.lo[0]), .i_box_min_y(cur_ray.lo[1]),
        .i_box_min_z(cur_ray.lo[2]),
        .i_box_max_packed(cur_ray.hi_xy), .i_box_max_z(cur_ray.hi_z),
        .i_t_window(cur_ray.win),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_hit(o_hit), .o_slabs_overlap(o_slabs_overlap), .o_t_near(o_t_near)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > TOP) return TOP;
        if (v < BOT) return BOT;
        return v;
    endfunction

    // floor((plane - org) * inv / 2^16), saturated
    function automatic longint plane_dist(longint plane, longint org, longint inv);
        longint diff, p;
        diff = plane - org;
        p = diff * inv;
        return sat32(p >>> 16);
    endfunction

    function automatic t_slab_res slab_predict(t_ray_box r);
        longint o[3], inv[3], lo[3], hi[3], ent[3], ext[3];
        longint t0, t1, tmin, tmax;
        t_slab_res res;
        res = '0;
        for (int a = 0; a < 3; a++) begin
            o[a] = longint'(r.org[a]);
            lo[a] = longint'(r.lo[a]);
            if (r.dir[a] == 0) inv[a] = TOP;
            else inv[a] = sat32(64'sd4294967296 / longint'(r.dir[a]));
        end
        hi[0] = longint'($signed(r.hi_xy[63:32]));
        hi[1] = longint'($signed(r.hi_xy[31:0]));
        hi[2] = longint'(r.hi_z);
        t0 = longint'($signed(r.win[63:32]));
        t1 = longint'($signed(r.win[31:0]));
        for (int a = 0; a < 3; a++) begin
            ent[a] = plane_dist(inv[a] < 0 ? hi[a] : lo[a], o[a], inv[a]);
            ext[a] = plane_dist(inv[a] < 0 ? lo[a] : hi[a], o[a], inv[a]);
        end
        tmin = ent[0];
        tmax = ext[0];
        for (int a = 1; a < 3; a++) begin
            if (tmin > ext[a] || ent[a] > tmax) return res;
            if (ent[a] > tmin) tmin = ent[a];
            if (ext[a] < tmax) tmax = ext[a];
        end
        res.hit = (tmin < t1 && tmax > t0);
        res.overlap = 1'b1;
        res.t_near = t_coord'(tmin < tmax ? tmin : tmax);
        return res;
    endfunction

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            2: return t_coord'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: return ($urandom_range(0, 1)) ? COORD_TOP : COORD_BOTTOM;
        endcase
    endfunction

    // Random ray; in mode 1 half the rays are aimed near the box to get past early rejects
    function automatic t_ray_box rand_ray(int mode);
        t_ray_box r;
        t_coord hx, hy;
        for (int a = 0; a < 3; a++) begin
            r.org[a] = rand_coord(mode);
            r.dir[a] = ($urandom_range(0, 9) == 0) ? '0 : rand_coord(mode);
            r.lo[a] = rand_coord(mode);
        end
        if (mode == 1 && $urandom_range(0, 1)) begin
            r.dir[0] = r.lo[0] - r.org[0] + 32'sh0001_0000;
            r.dir[1] = r.lo[1] - r.org[1] + 32'sh0001_0000;
            r.dir[2] = r.lo[2] - r.org[2] + 32'sh0001_0000;
            hx = r.lo[0] + t_coord'($urandom_range(0, 32'h0004_0000));
            hy = r.lo[1] + t_coord'($urandom_range(0, 32'h0004_0000));
            r.hi_z = r.lo[2] + t_coord'($urandom_range(0, 32'h0004_0000));
        end else begin
            hx = rand_coord(mode);
            hy = rand_coord(mode);
            r.hi_z = rand_coord(mode);
        end
        r.hi_xy = {hx, hy};
        r.win = {rand_coord(mode == 0 ? 0 : 1), rand_coord(mode == 0 ? 0 : 2)};
        return r;
    endfunction

    // Driver: present the next pending ray, advance on transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                void'(ray_queue.pop_front());
            end
            if (ray_queue.size() > 0 && (!in_valid || in_taken)) begin
                if ($urandom_range(0, 99) < idle_pct) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    cur_ray <= ray_queue[0];
                end
            end else if (ray_queue.size() == 0) begin
                in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        t_slab_res got, want;
        // input transfer at this edge, seen by the driver at the next falling edge
        in_taken = i_rst_n && in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                expected_hits = {expected_hits, slab_predict(cur_ray)};
            end
            if (o_out_valid && !out_stall) begin
                got = '{o_hit, o_slabs_overlap, o_t_near};
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    failed = 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (got.hit !== want.hit)
                        $display("%0t: hit exp %b got %b", $realtime, want.hit, got.hit);
                    if (got.overlap !== want.overlap)
                        $display("%0t: slabs_overlap exp %b got %b", $realtime,
                                 want.overlap, got.overlap);
                    if (got.t_near !== want.t_near)
                        $display("%0t: t_near exp %h got %h", $realtime,
                                 want.t_near, got.t_near);
                    if (got !== want) failed = 1;
                end
            end
        end
    end

    task automatic drain_all();
        while (ray_queue.size() > 0 || in_valid) @(posedge i_clk);
        while (expected_hits.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        t_ray_box r;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero directions, rejects, degenerate box
        r = '0;
        ray_queue = {ray_queue, r};
        r.dir = {3{32'sh0001_0000}};
        r.lo = {3{32'sh0001_0000}};
        r.hi_xy = {32'sh0002_0000, 32'sh0002_0000};
        r.hi_z = 32'sh0002_0000;
        r.win = {32'sh0000_0000, 32'sh0010_0000};
        ray_queue = {ray_queue, r};
        r.win = {32'sh0010_0000, 32'sh0020_0000};
        ray_queue = {ray_queue, r};
        r.dir = {3{-32'sh0001_0000}};
        ray_queue = {ray_queue, r};
        r.dir = '0;
        ray_queue = {ray_queue, r};
        r.dir = {32'sh0001_0000, 32'sh0000_0000, -32'sh0000_0001};
        ray_queue = {ray_queue, r};
        r.lo = {3{32'sh0003_0000}};
        ray_queue = {ray_queue, r};
        r.lo[2] = 32'sh0001_0000;
        r.hi_z = 32'sh0008_0000;
        r.lo[1] = 32'sh0005_0000;
        ray_queue = {ray_queue, r};
        r = '1;
        ray_queue = {ray_queue, r};
        r = {14{1'b1, 31'b0}};
        ray_queue = {ray_queue, r};
        r = '0;
        r.dir = {COORD_TOP, COORD_BOTTOM, 32'sh0000_0001};
        r.org = {COORD_BOTTOM, COORD_TOP, COORD_BOTTOM};
        r.lo = {COORD_TOP, COORD_BOTTOM, COORD_TOP};
        r.hi_xy = {COORD_BOTTOM, COORD_TOP};
        r.hi_z = COORD_BOTTOM;
        r.win = {COORD_BOTTOM, COORD_TOP};
        ray_queue = {ray_queue, r};
        r.dir = {-32'sh0000_0001, 32'sh0000_0002, -32'sh0000_0002};
        ray_queue = {ray_queue, r};
        for (int k = 0; k < 8; k++) ray_queue = {ray_queue, rand_ray(3)};
        drain_all();

        // Random phases with different idle and stall rates
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                3: begin idle_pct = 18; stall_pct = 18; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int k = 0; k < 125; k++) begin
                ray_queue = {ray_queue, rand_ray($urandom_range(0, 9) < 6 ? 1 :
                                                 $urandom_range(0, 3))};
            end
            while (ray_queue.size() > 0 || in_valid) @(posedge i_clk);
            if (ph == 1) drain_all();
        end
        drain_all();
        repeat (40) @(posedge i_clk);
        if (!failed && expected_hits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/rbst_pkg.sv
hdl/rbst_recip.sv
hdl/ray_box_slab_test.sv
verif/tb_ray_box_slab_test.sv
